// ===== rtl/ufs_pkg.sv =====
// ufs_pkg: shared types, constants and lookup functions of the URL field splitter.
// No dependencies. Used by every module in rtl/.

package ufs_pkg;

    localparam int C_MAX_URL_BYTES = 1024;
    localparam int C_IDX_W         = $clog2(C_MAX_URL_BYTES + 1);
    localparam int C_START_W       = 10;
    localparam int C_LEN_W         = 11;
    localparam int C_NFIELDS       = 6;
    localparam int C_Q_DEPTH       = 4;

    // field kinds, in emit order
    localparam logic [2:0] K_PROTO = 3'd0;
    localparam logic [2:0] K_USER  = 3'd1;
    localparam logic [2:0] K_PASS  = 3'd2;
    localparam logic [2:0] K_HOST  = 3'd3;
    localparam logic [2:0] K_PORT  = 3'd4;
    localparam logic [2:0] K_PATH  = 3'd5;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [15:0] C_PORT_HTTP  = 16'd80;
    localparam logic [15:0] C_PORT_HTTPS = 16'd443;

    // protocol match codes
    localparam logic [1:0] PM_NONE  = 2'd0;
    localparam logic [1:0] PM_HTTP  = 2'd1;
    localparam logic [1:0] PM_HTTPS = 2'd2;

    // text match codes: 0..5 = prefix length of "https" seen, TM_MISS = mismatch
    localparam logic [2:0] TM_HTTP  = 3'd4;
    localparam logic [2:0] TM_HTTPS = 3'd5;
    localparam logic [2:0] TM_MISS  = 3'd7;

    typedef enum logic [3:0] {
        ST_FAIL  = 4'd0,
        ST_START = 4'd1,
        ST_PROT  = 4'd2,
        ST_SL1   = 4'd3,
        ST_SL2   = 4'd4,
        ST_HST1  = 4'd5,
        ST_HST   = 4'd6,
        ST_PORT1 = 4'd7,
        ST_PORT  = 4'd8,
        ST_PTH1  = 4'd9,
        ST_PTH   = 4'd10,
        ST_END   = 4'd11
    } t_pstate;

    typedef enum logic [2:0] {
        CL_COLON = 3'd0,
        CL_SPACE = 3'd1,
        CL_SLASH = 3'd2,
        CL_AT    = 3'd3,
        CL_OTHER = 3'd4
    } t_cls;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } t_in;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic        field_present;
        logic [9:0]  field_start;
        logic [10:0] field_length;
        logic        path_is_default;
        logic        parse_ok;
        logic [15:0] port_value;
        logic        secure;
        logic        last_result;
    } t_out;

    // queue entry: request plus its character class
    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
        t_cls       cls;
    } t_qent;

    // finished URL handed from parser to result sequencer
    typedef struct packed {
        logic [C_NFIELDS-1:0][C_START_W-1:0] start;
        logic [C_NFIELDS-1:0][C_LEN_W-1:0]   len;
        logic                                path_def;
        logic                                ok;
        logic [15:0]                         port_value;
        logic                                secure;
    } t_snap;

    function automatic t_cls f_class(input logic [7:0] c);
        t_cls r;
        if (c == 8'h3A || c == 8'h00) begin
            r = CL_COLON;
        end else if (c == 8'h20 || (c >= 8'h08 && c <= 8'h0D)) begin
            r = CL_SPACE;
        end else if (c == 8'h2F) begin
            r = CL_SLASH;
        end else if (c == 8'h40) begin
            r = CL_AT;
        end else begin
            r = CL_OTHER;
        end
        return r;
    endfunction

    function automatic logic [7:0] f_https(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h68; // h
            3'd1:    r = 8'h74; // t
            3'd2:    r = 8'h74; // t
            3'd3:    r = 8'h70; // p
            3'd4:    r = 8'h73; // s
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // transition table, columns colon/space/slash/at/other
    function automatic t_pstate f_next(input t_pstate st, input t_cls cl);
        t_pstate r;
        r = ST_FAIL;
        case (st)
            ST_START: begin
                case (cl)
                    CL_SPACE: r = ST_START;
                    CL_SLASH: r = ST_SL2;
                    CL_OTHER: r = ST_PROT;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_PROT: begin
                case (cl)
                    CL_COLON: r = ST_SL1;
                    CL_SLASH: r = ST_PTH1;
                    CL_AT:    r = ST_HST1;
                    CL_OTHER: r = ST_PROT;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_SL1: begin
                case (cl)
                    CL_SLASH: r = ST_SL2;
                    CL_OTHER: r = ST_PORT;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_SL2: begin
                case (cl)
                    CL_SLASH: r = ST_HST1;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_HST1: begin
                case (cl)
                    CL_OTHER: r = ST_HST;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_HST: begin
                case (cl)
                    CL_COLON: r = ST_PORT1;
                    CL_SLASH: r = ST_PTH1;
                    CL_AT:    r = ST_HST1;
                    CL_OTHER: r = ST_HST;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_PORT1: begin
                case (cl)
                    CL_OTHER: r = ST_PORT;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_PORT: begin
                case (cl)
                    CL_SLASH: r = ST_PTH1;
                    CL_AT:    r = ST_HST1;
                    CL_OTHER: r = ST_PORT;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_PTH1: begin
                case (cl)
                    CL_OTHER: r = ST_PTH;
                    default:  r = ST_FAIL;
                endcase
            end
            ST_PTH: begin
                case (cl)
                    CL_SPACE: r = ST_END;
                    default:  r = ST_PTH;
                endcase
            end
            default: r = ST_FAIL;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ufs_front.sv =====
// ufs_front: input side of the splitter; classifies each request and queues it.
// Depends on ufs_pkg (t_in, t_qent, f_class, C_Q_DEPTH).

module ufs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ufs_pkg::t_in   i_data,
    output logic           o_q_valid,
    output ufs_pkg::t_qent o_q_data,
    input  logic           i_q_pop
);

    localparam int PTR_W = $clog2(ufs_pkg::C_Q_DEPTH);
    localparam int CNT_W = $clog2(ufs_pkg::C_Q_DEPTH + 1);

    ufs_pkg::t_qent r_mem [ufs_pkg::C_Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;
    ufs_pkg::t_qent   ent;

    assign o_ready   = (r_cnt != CNT_W'(ufs_pkg::C_Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rd];

    always_comb begin
        ent.op      = i_data.op;
        ent.byte_in = i_data.byte_in;
        ent.cls     = ufs_pkg::f_class(i_data.byte_in);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/ufs_parse.sv =====
// ufs_parse: table-driven URL parser; one byte per cycle, hands a finished URL
// to the result sequencer, when free, at end of string. Depends on ufs_pkg.

module ufs_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ufs_pkg::t_qent i_q_data,
    output logic           o_q_pop,
    output logic           o_snap_valid,
    output ufs_pkg::t_snap o_snap,
    input  logic           i_snap_ready
);

    localparam int IW = ufs_pkg::C_IDX_W;
    localparam int SW = ufs_pkg::C_START_W;
    localparam int LW = ufs_pkg::C_LEN_W;
    localparam int NF = ufs_pkg::C_NFIELDS;

    ufs_pkg::t_pstate r_state, n_state;
    logic             r_stopped, n_stopped;
    logic [IW-1:0]    r_idx, n_idx;
    logic [SW-1:0]    r_begin, n_begin;
    logic             r_dok, n_dok;
    logic [15:0]      r_num, n_num;
    logic [2:0]       r_tm, n_tm;
    logic [NF-1:0][SW-1:0] r_start, n_start;
    logic [NF-1:0][LW-1:0] r_len, n_len;
    logic             r_port_ok, n_port_ok;
    logic [15:0]      r_port_val, n_port_val;
    logic [1:0]       r_pm, n_pm;

    logic             is_eos, take, too_long, chg, clr, halt;
    ufs_pkg::t_pstate nx;
    logic [7:0]       c;
    logic [LW-1:0]    span_l;
    logic             is_digit;
    logic [3:0]       dig;
    logic [15:0]      num_base;
    logic [2:0]       tm_base;
    logic [19:0]      num_ext;
    logic             has_port;

    assign c        = i_q_data.byte_in;
    assign is_eos   = (i_q_data.op == ufs_pkg::OP_EOS);
    assign o_q_pop  = i_q_valid && (!is_eos || i_snap_ready);
    assign o_snap_valid = i_q_valid && is_eos;
    assign take     = o_q_pop && !is_eos && !r_stopped;
    assign too_long = (r_idx >= IW'(ufs_pkg::C_MAX_URL_BYTES));
    assign nx       = ufs_pkg::f_next(r_state, i_q_data.cls);
    assign chg      = (nx != r_state);
    assign halt     = (nx == ufs_pkg::ST_FAIL) || (nx == ufs_pkg::ST_END);
    assign span_l   = LW'(r_idx - IW'(r_begin));
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign dig      = 4'(c - 8'h30);

    // item restarts on every transition that closes or opens a span
    always_comb begin
        clr = 1'b0;
        if (chg) begin
            case (nx)
                ufs_pkg::ST_SL1, ufs_pkg::ST_PORT1, ufs_pkg::ST_HST1,
                ufs_pkg::ST_PTH1, ufs_pkg::ST_END: clr = 1'b1;
                ufs_pkg::ST_PORT: clr = (r_state == ufs_pkg::ST_SL1);
                default: clr = 1'b0;
            endcase
            if (r_state == ufs_pkg::ST_START || r_state == ufs_pkg::ST_HST1 ||
                r_state == ufs_pkg::ST_PORT1) begin
                clr = 1'b1;
            end
        end
    end

    assign num_base = clr ? 16'd0 : r_num;
    assign tm_base  = clr ? 3'd0 : r_tm;
    assign num_ext  = {4'd0, num_base} * 20'd10 + 20'(dig);

    // next state
    always_comb begin
        n_state   = r_state;
        n_stopped = r_stopped;
        if (o_q_pop && is_eos) begin
            n_state   = ufs_pkg::ST_START;
            n_stopped = 1'b0;
        end else if (take) begin
            if (too_long) begin
                n_state   = ufs_pkg::ST_FAIL;
                n_stopped = 1'b1;
            end else begin
                n_state = nx;
                if (halt) begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    // item and span updates
    always_comb begin
        n_idx      = r_idx;
        n_begin    = r_begin;
        n_dok      = r_dok;
        n_num      = r_num;
        n_tm       = r_tm;
        n_start    = r_start;
        n_len      = r_len;
        n_port_ok  = r_port_ok;
        n_port_val = r_port_val;
        n_pm       = r_pm;
        if (o_q_pop && is_eos) begin
            n_idx      = '0;
            n_begin    = '0;
            n_dok      = 1'b1;
            n_num      = '0;
            n_tm       = '0;
            n_start    = '0;
            n_len      = '0;
            n_port_ok  = 1'b1;
            n_port_val = '0;
            n_pm       = ufs_pkg::PM_NONE;
        end else if (take && !too_long) begin
            if (chg) begin
                case (nx)
                    ufs_pkg::ST_SL1: begin
                        n_start[ufs_pkg::K_PROTO] = r_begin;
                        n_len[ufs_pkg::K_PROTO]   = span_l;
                        n_pm = (r_tm == ufs_pkg::TM_HTTP)  ? ufs_pkg::PM_HTTP :
                               (r_tm == ufs_pkg::TM_HTTPS) ? ufs_pkg::PM_HTTPS :
                                                             ufs_pkg::PM_NONE;
                    end
                    ufs_pkg::ST_PORT: begin
                        // "name:port" with no slashes: protocol was really a host
                        if (r_state == ufs_pkg::ST_SL1) begin
                            n_start[ufs_pkg::K_HOST]  = r_start[ufs_pkg::K_PROTO];
                            n_len[ufs_pkg::K_HOST]    = r_len[ufs_pkg::K_PROTO];
                            n_start[ufs_pkg::K_PROTO] = '0;
                            n_len[ufs_pkg::K_PROTO]   = '0;
                            n_pm = ufs_pkg::PM_NONE;
                        end
                    end
                    ufs_pkg::ST_PORT1: begin
                        n_start[ufs_pkg::K_HOST] = r_begin;
                        n_len[ufs_pkg::K_HOST]   = span_l;
                    end
                    ufs_pkg::ST_HST1: begin
                        if (r_state == ufs_pkg::ST_PROT || r_state == ufs_pkg::ST_HST) begin
                            n_start[ufs_pkg::K_USER] = r_begin;
                            n_len[ufs_pkg::K_USER]   = span_l;
                        end else if (r_state == ufs_pkg::ST_PORT) begin
                            // "user:pass@": host/port were credentials
                            n_start[ufs_pkg::K_USER] = r_start[ufs_pkg::K_HOST];
                            n_len[ufs_pkg::K_USER]   = r_len[ufs_pkg::K_HOST];
                            n_start[ufs_pkg::K_PASS] = r_begin;
                            n_len[ufs_pkg::K_PASS]   = span_l;
                            n_start[ufs_pkg::K_HOST] = '0;
                            n_len[ufs_pkg::K_HOST]   = '0;
                        end
                    end
                    ufs_pkg::ST_PTH1: begin
                        if (r_state == ufs_pkg::ST_PORT) begin
                            n_start[ufs_pkg::K_PORT] = r_begin;
                            n_len[ufs_pkg::K_PORT]   = span_l;
                            n_port_ok  = r_dok;
                            n_port_val = r_num;
                        end else if (r_state == ufs_pkg::ST_HST ||
                                     r_state == ufs_pkg::ST_PROT) begin
                            n_start[ufs_pkg::K_HOST] = r_begin;
                            n_len[ufs_pkg::K_HOST]   = span_l;
                        end
                    end
                    ufs_pkg::ST_END: begin
                        n_start[ufs_pkg::K_PATH] = r_begin;
                        n_len[ufs_pkg::K_PATH]   = span_l;
                    end
                    default: begin
                    end
                endcase
            end
            if (clr) begin
                n_begin = r_idx[SW-1:0];
                n_dok   = 1'b1;
                n_num   = '0;
                n_tm    = '0;
            end
            if (!halt) begin
                // append byte to the current item
                if (is_digit) begin
                    n_num = (num_ext > 20'd65535) ? 16'hFFFF : num_ext[15:0];
                    n_dok = clr ? 1'b1 : r_dok;
                end else begin
                    n_dok = 1'b0;
                end
                if (tm_base < 3'd5 && c == ufs_pkg::f_https(tm_base)) begin
                    n_tm = tm_base + 3'd1;
                end else begin
                    n_tm = ufs_pkg::TM_MISS;
                end
                n_idx = r_idx + IW'(1);
            end
        end
    end

    // end-of-string wrap-up of the URL currently held
    always_comb begin
        o_snap.start    = r_start;
        o_snap.len      = r_len;
        o_snap.path_def = 1'b0;
        if (r_state == ufs_pkg::ST_PTH) begin
            if (span_l != '0) begin
                o_snap.start[ufs_pkg::K_PATH] = r_begin;
                o_snap.len[ufs_pkg::K_PATH]   = span_l;
            end else begin
                o_snap.start[ufs_pkg::K_PATH] = '0;
                o_snap.len[ufs_pkg::K_PATH]   = '0;
                o_snap.path_def = 1'b1;
            end
        end else if (r_state == ufs_pkg::ST_HST) begin
            o_snap.start[ufs_pkg::K_HOST] = r_begin;
            o_snap.len[ufs_pkg::K_HOST]   = span_l;
            o_snap.start[ufs_pkg::K_PATH] = '0;
            o_snap.len[ufs_pkg::K_PATH]   = '0;
            o_snap.path_def = 1'b1;
        end
        has_port  = (r_len[ufs_pkg::K_PORT] != '0);
        o_snap.ok = (r_state != ufs_pkg::ST_FAIL) && !(has_port && !r_port_ok);
        o_snap.port_value = '0;
        o_snap.secure     = 1'b0;
        if (o_snap.ok) begin
            if (has_port) begin
                o_snap.port_value = r_port_val;
            end else begin
                o_snap.port_value = (r_pm == ufs_pkg::PM_HTTPS) ? ufs_pkg::C_PORT_HTTPS
                                                                 : ufs_pkg::C_PORT_HTTP;
            end
            if (r_pm == ufs_pkg::PM_HTTPS) begin
                o_snap.secure = 1'b1;
            end else if (r_pm == ufs_pkg::PM_HTTP) begin
                o_snap.secure = 1'b0;
            end else begin
                o_snap.secure = has_port && (r_port_val == ufs_pkg::C_PORT_HTTPS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ufs_pkg::ST_START;
            r_stopped  <= 1'b0;
            r_idx      <= '0;
            r_begin    <= '0;
            r_dok      <= 1'b1;
            r_num      <= '0;
            r_tm       <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_port_ok  <= 1'b1;
            r_port_val <= '0;
            r_pm       <= ufs_pkg::PM_NONE;
        end else begin
            r_state    <= n_state;
            r_stopped  <= n_stopped;
            r_idx      <= n_idx;
            r_begin    <= n_begin;
            r_dok      <= n_dok;
            r_num      <= n_num;
            r_tm       <= n_tm;
            r_start    <= n_start;
            r_len      <= n_len;
            r_port_ok  <= n_port_ok;
            r_port_val <= n_port_val;
            r_pm       <= n_pm;
        end
    end

endmodule

// ===== rtl/ufs_emit.sv =====
// ufs_emit: result sequencer; holds one finished URL and plays out its six
// field results through a registered output. Depends on ufs_pkg.

module ufs_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_snap_valid,
    input  ufs_pkg::t_snap i_snap,
    output logic           o_snap_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output ufs_pkg::t_out  o_data
);

    ufs_pkg::t_snap r_snap;
    logic           r_busy;
    logic [2:0]     r_k;
    logic           r_out_valid;
    ufs_pkg::t_out  r_out, res;
    logic           adv, load, def_k, pres;

    assign o_snap_ready = !r_busy;
    assign load    = i_snap_valid && !r_busy;
    assign adv     = r_busy && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        def_k = r_snap.ok && (r_k == ufs_pkg::K_PATH) && r_snap.path_def;
        pres  = r_snap.ok && (def_k || (r_snap.len[r_k] != '0));
        res.field_kind      = r_k;
        res.field_present   = pres;
        res.field_start     = (pres && !def_k) ? r_snap.start[r_k] : '0;
        res.field_length    = (pres && !def_k) ? r_snap.len[r_k] : '0;
        res.path_is_default = def_k;
        res.parse_ok        = r_snap.ok;
        res.port_value      = r_snap.port_value;
        res.secure          = r_snap.secure;
        res.last_result     = (r_k == ufs_pkg::K_PATH);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_snap <= i_snap;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= ufs_pkg::K_PROTO;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_k    <= ufs_pkg::K_PROTO;
            end else if (adv) begin
                r_k <= r_k + 3'd1;
                if (r_k == ufs_pkg::K_PATH) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/url_field_splitter.sv =====
// url_field_splitter: top level; front classifier/queue, parser, result sequencer.
// Depends on ufs_pkg, ufs_front, ufs_parse, ufs_emit.

// Feed a URL one byte per request (op = 0), then one end-of-string request
// (op = 1). Bytes are taken at one per clock: each is classed (colon, space,
// slash, at, other) on entry, parked in a four-entry queue and then run
// through the 12-state table parser, which does one table step and its span
// updates per cycle. An end-of-string request hands the finished spans to the
// result sequencer and clears the parser in the same cycle, so the next URL's
// bytes flow on at once. The sequencer then plays out six results, protocol,
// user, password, host, port, path, one per cycle while the sink is ready;
// the sixth carries last_result. The sequencer holds one URL, so a second
// end-of-string waits in the queue until the sequencer has registered the
// previous URL's sixth result. Input ready drops only when the queue is
// full. An accepted end-of-string is written into the queue, loaded into
// the sequencer and then registered as the first result. Reset is
// synchronous, with no clearing pass. Spans are byte offsets; at most 1024
// bytes per URL are taken, a longer URL fails. A failed parse reports
// every field absent with port 0.

module url_field_splitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ufs_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ufs_pkg::t_out o_data
);

    logic           q_valid, q_pop;
    ufs_pkg::t_qent q_data;
    logic           snap_valid, snap_ready;
    ufs_pkg::t_snap snap;

    // front: classify and queue requests
    ufs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    // back: table parser, one byte per cycle; an end of string waits for the sequencer
    ufs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    // back: six results per URL through a registered output
    ufs_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

    // results of one URL follow back to back in field order
    a_kind_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_result) |=>
        (o_valid && (o_data.field_kind == $past(o_data.field_kind) + 3'd1)))
        else $error("field results out of sequence");

    a_last_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.last_result) |-> (o_data.field_kind == ufs_pkg::K_PATH))
        else $error("last result is not the path");

    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.parse_ok) |->
        (!o_data.field_present && o_data.port_value == 16'd0 && !o_data.secure))
        else $error("failed parse reports data");

    a_def_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.path_is_default) |->
        (o_data.field_kind == ufs_pkg::K_PATH && o_data.field_present &&
         o_data.field_length == 11'd0))
        else $error("default path mark on wrong result");

endmodule
